### rtl/smd_pkg.sv
`timescale 1ns / 1ps

package smd_pkg;

  typedef enum logic [4:0] {
    OP_LIT    = 5'd0,
    OP_DROP   = 5'd1,
    OP_DROPD  = 5'd2,
    OP_DUP    = 5'd3,
    OP_DUPD   = 5'd4,
    OP_2DUP   = 5'd5,
    OP_OVER   = 5'd6,
    OP_PICK   = 5'd7,
    OP_SWAP   = 5'd8,
    OP_SWAPD  = 5'd9,
    OP_ROT    = 5'd10,
    OP_NROT   = 5'd11,
    OP_NEG    = 5'd12,
    OP_ADD    = 5'd13,
    OP_SUB    = 5'd14,
    OP_MUL    = 5'd15,
    OP_DIV    = 5'd16,
    OP_MOD    = 5'd17,
    OP_EQ     = 5'd18,
    OP_LAND   = 5'd19,
    OP_LOR    = 5'd20,
    OP_LNOT   = 5'd21,
    OP_BAND   = 5'd22,
    OP_BOR    = 5'd23,
    OP_BXOR   = 5'd24,
    OP_SHL    = 5'd25,
    OP_SHR    = 5'd26,
    OP_BNOT   = 5'd27,
    OP_EMIT   = 5'd28
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]  op;
    logic [63:0] literal;
    logic [1:0]  need;
    logic [2:0]  make;
    logic        known;
  } smd_cmd_t;

  function automatic logic [1:0] need_of(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd2;
    unique case (op) inside
      OP_LIT:                                    n = 2'd0;
      OP_DROP, OP_DUP, OP_NEG, OP_LNOT, OP_BNOT,
      OP_EMIT:                                   n = 2'd1;
      OP_PICK, OP_SWAPD, OP_ROT, OP_NROT:        n = 2'd3;
      OP_DROPD, OP_DUPD, OP_2DUP, OP_OVER, OP_SWAP, OP_ADD, OP_SUB, OP_MUL,
      OP_DIV, OP_MOD, OP_EQ, OP_LAND, OP_LOR, OP_BAND, OP_BOR, OP_BXOR,
      OP_SHL, OP_SHR:                            n = 2'd2;
      default:                                   n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] make_of(input logic [4:0] op);
    logic [2:0] m;
    m = 3'd1;
    unique case (op) inside
      OP_DROP, OP_EMIT:                          m = 3'd0;
      OP_DUP, OP_SWAP:                           m = 3'd2;
      OP_DUPD, OP_OVER, OP_SWAPD, OP_ROT,
      OP_NROT:                                   m = 3'd3;
      OP_2DUP, OP_PICK:                          m = 3'd4;
      OP_LIT, OP_DROPD, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ,
      OP_LAND, OP_LOR, OP_LNOT, OP_BAND, OP_BOR, OP_BXOR, OP_SHL, OP_SHR,
      OP_BNOT:                                   m = 3'd1;
      default:                                   m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

### rtl/smd_front.sv
`timescale 1ns / 1ps

module smd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [4:0]        op_i,
  input  logic [63:0]       literal_i,
  output logic              cmd_valid_o,
  output smd_pkg::smd_cmd_t cmd_o,
  input  logic              cmd_pop_i
);
  import smd_pkg::*;

  smd_cmd_t   queue_q [2];
  smd_cmd_t   cmd_in;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  always_comb begin
    cmd_in.op      = op_i;
    cmd_in.literal = literal_i;
    cmd_in.need    = need_of(op_i);
    cmd_in.make    = make_of(op_i);
    cmd_in.known   = (op_i <= OP_EMIT);
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/smd_divider.sv
`timescale 1ns / 1ps

module smd_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o,
  output logic [63:0] remainder_o
);

  logic [63:0] quo_q, rem_q, div_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q, qneg_q, rneg_q;
  logic [64:0] shifted, diff;

  assign shifted     = {rem_q, quo_q[63]};
  assign diff        = shifted - {1'b0, div_q};
  assign done_o      = done_q;
  assign quotient_o  = qneg_q ? 64'(0) - quo_q : quo_q;
  assign remainder_o = rneg_q ? 64'(0) - rem_q : rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i[63] ? 64'(0) - dividend_i : dividend_i;
      div_q  <= divisor_i[63] ? 64'(0) - divisor_i : divisor_i;
      rem_q  <= '0;
      qneg_q <= dividend_i[63] ^ divisor_i[63];
      rneg_q <= dividend_i[63];
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/smd_back.sv
`timescale 1ns / 1ps

module smd_back #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  smd_pkg::smd_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       top_value_o,
  output logic [10:0]       stack_depth_o,
  output logic [1:0]        status_o
);
  import smd_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_WAIT  = 10'b0000000100,
    S_EXEC  = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WRITE = 10'b0001000000,
    S_TOP   = 10'b0010000000,
    S_TOPW  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e          state_q;
  logic [63:0]     mem [STACK_DEPTH];
  logic [63:0]     rdata_q;
  logic [AW-1:0]   raddr, waddr;
  logic            we;

  logic [SPW-1:0]  sp_q, base_q;
  logic [2:0]      cnt_q;
  logic [1:0]      mstep_q;
  smd_cmd_t        cmd_q;
  logic [63:0]     t_q [3];
  logic [63:0]     r_q [4];
  logic [63:0]     r_d [4];
  logic [63:0]     prod_q, acc_q, top_q;
  logic [1:0]      status_q;
  logic            emit_q;

  logic [SPW:0]    grow;
  logic            div_start, div_done;
  logic [63:0]     quo, rem;
  logic            is_divop;

  smd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (t_q[0]),
    .divisor_i  (t_q[1]),
    .done_o     (div_done),
    .quotient_o (quo),
    .remainder_o(rem)
  );

  assign grow      = {1'b0, sp_q} - (SPW + 1)'(cmd_i.need) + (SPW + 1)'(cmd_i.make);
  assign is_divop  = (cmd_q.op == OP_DIV) || (cmd_q.op == OP_MOD);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign div_start = (state_q == S_EXEC) && is_divop && (t_q[1] != '0);

  assign raddr = (state_q == S_TOP) ? AW'(sp_q - SPW'(1)) : AW'(base_q + SPW'(cnt_q));
  assign waddr = AW'(base_q + SPW'(cnt_q));
  assign we    = (state_q == S_WRITE);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= r_q[cnt_q[1:0]];
    rdata_q <= mem[raddr];
  end

  always_comb begin
    r_d[0] = '0;
    r_d[1] = '0;
    r_d[2] = '0;
    r_d[3] = '0;
    case (cmd_q.op)
      OP_LIT:   r_d[0] = cmd_q.literal;
      OP_DROPD: r_d[0] = t_q[1];
      OP_DUP:   begin r_d[0] = t_q[0]; r_d[1] = t_q[0]; end
      OP_DUPD:  begin r_d[0] = t_q[0]; r_d[1] = t_q[0]; r_d[2] = t_q[1]; end
      OP_2DUP:  begin
        r_d[0] = t_q[0]; r_d[1] = t_q[1]; r_d[2] = t_q[0]; r_d[3] = t_q[1];
      end
      OP_OVER:  begin r_d[0] = t_q[0]; r_d[1] = t_q[1]; r_d[2] = t_q[0]; end
      OP_PICK:  begin
        r_d[0] = t_q[0]; r_d[1] = t_q[1]; r_d[2] = t_q[2]; r_d[3] = t_q[0];
      end
      OP_SWAP:  begin r_d[0] = t_q[1]; r_d[1] = t_q[0]; end
      OP_SWAPD: begin r_d[0] = t_q[1]; r_d[1] = t_q[0]; r_d[2] = t_q[2]; end
      OP_ROT:   begin r_d[0] = t_q[1]; r_d[1] = t_q[2]; r_d[2] = t_q[0]; end
      OP_NROT:  begin r_d[0] = t_q[2]; r_d[1] = t_q[0]; r_d[2] = t_q[1]; end
      OP_NEG:   r_d[0] = 64'(0) - t_q[0];
      OP_ADD:   r_d[0] = t_q[0] + t_q[1];
      OP_SUB:   r_d[0] = t_q[0] - t_q[1];
      OP_EQ:    r_d[0] = 64'(t_q[0] == t_q[1]);
      OP_LAND:  r_d[0] = 64'((t_q[0] != '0) && (t_q[1] != '0));
      OP_LOR:   r_d[0] = 64'((t_q[0] != '0) || (t_q[1] != '0));
      OP_LNOT:  r_d[0] = 64'(t_q[0] == '0);
      OP_BAND:  r_d[0] = t_q[0] & t_q[1];
      OP_BOR:   r_d[0] = t_q[0] | t_q[1];
      OP_BXOR:  r_d[0] = t_q[0] ^ t_q[1];
      OP_SHL:   r_d[0] = t_q[0] << t_q[1][5:0];
      OP_SHR:   r_d[0] = 64'($signed(t_q[0]) >>> t_q[1][5:0]);
      OP_BNOT:  r_d[0] = ~t_q[0];
      default:  r_d[0] = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q    <= cmd_i;
        emit_q   <= 1'b0;
        status_q <= ST_OK;
        base_q   <= SPW'(sp_q - SPW'(cmd_i.need));
        cnt_q    <= '0;
        if (cmd_i.known && ({1'b0, sp_q} < (SPW + 1)'(cmd_i.need))) begin
          status_q <= ST_UNDER;
        end else if (cmd_i.known && (grow > (SPW + 1)'(STACK_DEPTH))) begin
          status_q <= ST_OVER;
        end
      end
      S_WAIT: begin
        t_q[cnt_q[1:0]] <= rdata_q;
        cnt_q           <= cnt_q + 3'd1;
      end
      S_EXEC: begin
        r_q     <= r_d;
        cnt_q   <= '0;
        mstep_q <= '0;
        if (is_divop && (t_q[1] == '0)) status_q <= ST_DIVZ;
        if (cmd_q.op == OP_EMIT) emit_q <= 1'b1;
      end
      S_MUL: begin
        mstep_q <= mstep_q + 2'd1;
        case (mstep_q)
          2'd0: prod_q <= t_q[0][31:0] * t_q[1][31:0];
          2'd1: begin
            acc_q  <= prod_q;
            prod_q <= t_q[0][31:0] * t_q[1][63:32];
          end
          2'd2: begin
            acc_q  <= acc_q + {prod_q[31:0], 32'd0};
            prod_q <= t_q[0][63:32] * t_q[1][31:0];
          end
          default: r_q[0] <= acc_q + {prod_q[31:0], 32'd0};
        endcase
      end
      S_DIV: begin
        if (div_done) r_q[0] <= (cmd_q.op == OP_DIV) ? quo : rem;
      end
      S_WRITE: cnt_q <= cnt_q + 3'd1;
      S_TOP: begin
        if (emit_q) top_q <= t_q[0];
        else if (sp_q == '0) top_q <= '0;
      end
      S_TOPW: top_q <= rdata_q;
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (!cmd_i.known || ({1'b0, sp_q} < (SPW + 1)'(cmd_i.need)) ||
                (grow > (SPW + 1)'(STACK_DEPTH))) begin
              state_q <= S_TOP;
            end else if (cmd_i.need == 2'd0) begin
              state_q <= S_EXEC;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_WAIT;
        S_WAIT: begin
          state_q <= (cnt_q + 3'd1 == 3'(cmd_q.need)) ? S_EXEC : S_READ;
        end
        S_EXEC: begin
          if (is_divop && (t_q[1] == '0)) begin
            state_q <= S_TOP;
          end else if (cmd_q.op == OP_MUL) begin
            state_q <= S_MUL;
          end else if (is_divop) begin
            state_q <= S_DIV;
          end else if (cmd_q.make == 3'd0) begin
            sp_q    <= base_q;
            state_q <= S_TOP;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_MUL: if (mstep_q == 2'd3) state_q <= S_WRITE;
        S_DIV: if (div_done) state_q <= S_WRITE;
        S_WRITE: begin
          if (cnt_q + 3'd1 == cmd_q.make) begin
            sp_q    <= base_q + SPW'(cmd_q.make);
            state_q <= S_TOP;
          end
        end
        S_TOP: state_q <= (emit_q || (sp_q == '0)) ? S_DONE : S_TOPW;
        S_TOPW: state_q <= S_DONE;
        S_DONE: if (!out_valid_o || out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_o || out_ready_i)) begin
      top_value_o   <= top_q;
      stack_depth_o <= 11'(sp_q);
      status_o      <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_DONE) && (!out_valid_o || out_ready_i)) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule

### rtl/stack_machine_datapath_unit.sv
`timescale 1ns / 1ps

// Data stack and ALU of a stack machine. Each input transaction carries an
// opcode and a literal and yields exactly one output transaction with the new
// top of stack (or the emitted value), the stack depth and a status code. A
// two-entry command queue takes transactions while the execution sequencer is
// busy. Execution is sequential over a stack memory with one read and one write
// port: each operand is read in a read and a wait state and each result written
// in a write state, then the top of stack is read back (unless it was emitted or
// the stack is empty), followed by a hand-off state and a dispatch state.
// Multiply adds steps of 32-bit partial products; divide and modulo wait for
// the bit-serial divider. The stack memory needs no clearing pass after reset.
module stack_machine_datapath_unit #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op[4:0], literal[68:5], zero[71:69]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // top_value[63:0], stack_depth[74:64],
                                      // status[76:75], zero[79:77]
);
  import smd_pkg::*;

  smd_cmd_t    cmd;
  logic        cmd_valid, cmd_pop;
  logic [63:0] top_value;
  logic [10:0] stack_depth;
  logic [1:0]  status;

  smd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[4:0]),
    .literal_i  (s_axis_tdata[68:5]),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  smd_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .top_value_o  (top_value),
    .stack_depth_o(stack_depth),
    .status_o     (status)
  );

  assign m_axis_tdata = {3'b000, status, stack_depth, top_value};

endmodule

### tb/tb_stack_machine_datapath_unit.sv
`timescale 1ns / 1ps

module tb_stack_machine_datapath_unit;
  import smd_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int MAX_CYCLE = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] stack_depth;
    logic [63:0] top_value;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  stack_machine_datapath_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  logic [63:0] stack_mem [DEPTH];
  int          stack_ptr = 0;
  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  function automatic int need_count(logic [4:0] op);
    case (op)
      OP_LIT: return 0;
      OP_DROP, OP_DUP, OP_NEG, OP_LNOT, OP_BNOT, OP_EMIT: return 1;
      OP_PICK, OP_SWAPD, OP_ROT, OP_NROT: return 3;
      default: return (op > OP_EMIT) ? 0 : 2;
    endcase
  endfunction

  function automatic int make_count(logic [4:0] op);
    case (op)
      OP_DROP, OP_EMIT: return 0;
      OP_DUP, OP_SWAP: return 2;
      OP_DUPD, OP_OVER, OP_SWAPD, OP_ROT, OP_NROT: return 3;
      OP_2DUP, OP_PICK: return 4;
      default: return (op > OP_EMIT) ? 0 : 1;
    endcase
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic result_t stack_step(logic [4:0] op, logic [63:0] lit);
    result_t     res;
    logic [63:0] a[3];
    logic [63:0] r[4];
    logic [63:0] q;
    int          need;
    int          make;
    int          base;
    bit          emitted;
    need = need_count(op);
    make = make_count(op);
    emitted = 1'b0;
    res.status = ST_OK;
    res.top_value = '0;
    a = '{default: '0};
    r = '{default: '0};
    if (op <= OP_EMIT) begin
      if (stack_ptr < need) begin
        res.status = ST_UNDER;
      end else if (stack_ptr - need + make > DEPTH) begin
        res.status = ST_OVER;
      end else begin
        base = stack_ptr - need;
        for (int i = 0; i < need; i++) a[i] = stack_mem[base + i];
        if ((op == OP_DIV || op == OP_MOD) && a[1] == 0) begin
          res.status = ST_DIVZ;
        end else begin
          case (op)
            OP_LIT: r[0] = lit;
            OP_DROPD: r[0] = a[1];
            OP_DUP: r = '{a[0], a[0], 0, 0};
            OP_DUPD: r = '{a[0], a[0], a[1], 0};
            OP_2DUP: r = '{a[0], a[1], a[0], a[1]};
            OP_OVER: r = '{a[0], a[1], a[0], 0};
            OP_PICK: r = '{a[0], a[1], a[2], a[0]};
            OP_SWAP: r = '{a[1], a[0], 0, 0};
            OP_SWAPD: r = '{a[1], a[0], a[2], 0};
            OP_ROT: r = '{a[1], a[2], a[0], 0};
            OP_NROT: r = '{a[2], a[0], a[1], 0};
            OP_NEG: r[0] = -a[0];
            OP_ADD: r[0] = a[0] + a[1];
            OP_SUB: r[0] = a[0] - a[1];
            OP_MUL: r[0] = a[0] * a[1];
            OP_DIV: begin
              q = magnitude(a[0]) / magnitude(a[1]);
              r[0] = (a[0][63] ^ a[1][63]) ? -q : q;
            end
            OP_MOD: begin
              q = magnitude(a[0]) % magnitude(a[1]);
              r[0] = a[0][63] ? -q : q;
            end
            OP_EQ: r[0] = 64'(a[0] == a[1]);
            OP_LAND: r[0] = 64'(a[0] != 0 && a[1] != 0);
            OP_LOR: r[0] = 64'(a[0] != 0 || a[1] != 0);
            OP_LNOT: r[0] = 64'(a[0] == 0);
            OP_BAND: r[0] = a[0] & a[1];
            OP_BOR: r[0] = a[0] | a[1];
            OP_BXOR: r[0] = a[0] ^ a[1];
            OP_SHL: r[0] = a[0] << a[1][5:0];
            OP_SHR: r[0] = $signed(a[0]) >>> a[1][5:0];
            OP_BNOT: r[0] = ~a[0];
            OP_EMIT: begin
              emitted = 1'b1;
              res.top_value = a[0];
            end
            default: ;
          endcase
          for (int i = 0; i < make; i++) stack_mem[base + i] = r[i];
          stack_ptr = base + make;
        end
      end
    end
    if (!emitted) res.top_value = (stack_ptr > 0) ? stack_mem[stack_ptr - 1] : '0;
    res.stack_depth = 11'(stack_ptr);
    return res;
  endfunction

  task automatic send_item(logic [4:0] op, logic [63:0] lit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {3'b000, lit, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(stack_step(op, lit));
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return -64'($urandom_range(3));
      3: return 64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[76:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[79:77] !== 3'b000) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= MAX_CYCLE) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic drain_stack();
    while (stack_ptr > 0) send_item(OP_DROP, '0);
  endtask

  task automatic test_directed();
    send_item(OP_DROP, '0);
    send_item(OP_PICK, '0);
    send_item(OP_LIT, 64'h8000_0000_0000_0000);
    send_item(OP_LIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_DIV, '0);
    send_item(OP_LIT, 64'h8000_0000_0000_0000);
    send_item(OP_LIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_MOD, '0);
    send_item(OP_LIT, '0);
    send_item(OP_DIV, '0);
    send_item(OP_MOD, '0);
    send_item(OP_LIT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_LIT, 64'd127);
    send_item(OP_SHR, '0);
    send_item(OP_LIT, 64'd65);
    send_item(OP_SHL, '0);
    send_item(5'd29, '0);
    send_item(5'd31, '0);
    send_item(OP_EMIT, '0);
    for (int op = 0; op <= 28; op++) begin
      for (int i = 0; i < 3; i++) send_item(OP_LIT, rand_word());
      send_item(5'(op), rand_word());
    end
    drain_stack();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++) send_item(OP_LIT, {$urandom, $urandom});
    send_item(OP_LIT, '1);
    send_item(OP_DUP, '0);
    send_item(OP_2DUP, '0);
    send_item(OP_DROP, '0);
    send_item(OP_2DUP, '0);
    send_item(OP_DUP, '0);
    send_item(OP_PICK, '0);
  endtask

  task automatic test_random(int count);
    logic [4:0] op;
    for (int i = 0; i < count; i++) begin
      if (stack_ptr < 4 || $urandom_range(99) < 35) op = OP_LIT;
      else if ($urandom_range(99) < 5) op = 5'($urandom_range(31));
      else op = 5'($urandom_range(1, 28));
      send_item(op, rand_word());
      if (stack_ptr > 40) send_item(OP_DROP, '0);
    end
    drain_stack();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 17;
    recv_idle_pct = 88;
    test_directed();
    test_random(90);
    send_idle_pct = 88;
    recv_idle_pct = 17;
    test_random(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_overflow();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
